// ===== sv/bpa_pkg.sv =====
// bpa_pkg: shared constants, codes, control structs and a helper function
// for the bitmap page allocator. no dependencies.
package bpa_pkg;

  localparam int ADDR_W         = 48;
  localparam int PAGE_SHIFT     = 12;
  localparam int WORD_BITS      = 64;
  localparam int BIT_W          = 6;
  localparam int DEF_POOL_PAGES = 64;
  localparam int APB_DATA_W     = 64;
  localparam int APB_ADDR_W     = 4;

  // request kinds
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFREE  = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  // register index of pool_base
  localparam logic REG_POOL_BASE = 1'b0;

  typedef struct packed {
    logic load;    // request accepted, latch it and start the map read
    logic commit;  // update the map and load the result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;  // result register full and not taken this cycle
  } dp_stat_t;

  // index of the lowest clear bit of a map word
  function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

endpackage

// ===== sv/bitmap_page_allocator_unit.sv =====
// bitmap_page_allocator_unit: top level, config register port plus sequencer
// and map datapath. depends on bpa_pkg, bpa_ctrl, bpa_dp, bpa_ram.
//
//   port group   dir  handshake               payload
//   s_axis       in   tvalid/tready           tuser = cmd, tdata = free_addr
//   m_axis       out  tvalid/tready           tuser = status, tdata = page_addr
//   apb          in   psel/penable/pready     pool_base at byte address 0
//
// each request is accepted and its map word read (word chosen by the
// per-word full flags or by the free address), then the word is updated
// in the map ram and the result register loaded.
// the map reads as all free after reset through per-word valid flags; no
// clearing pass. a held result stalls the update, and no new request
// is accepted until the result register is free to take the pending one.
module bitmap_page_allocator_unit #(
  parameter int POOL_PAGES = bpa_pkg::DEF_POOL_PAGES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [bpa_pkg::ADDR_W-1:0]     s_axis_tdata,   // [47:0] free_addr
  input  logic                           s_axis_tuser,   // [0] cmd
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [bpa_pkg::ADDR_W-1:0]     m_axis_tdata,   // [47:0] page_addr
  output logic [1:0]                     m_axis_tuser,   // [1:0] status
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bpa_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [bpa_pkg::APB_DATA_W-1:0] pwdata,
  output logic [bpa_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import bpa_pkg::*;

  logic [ADDR_W-1:0] pool_base_q;
  logic              reg_idx;
  ctrl_cmd_t         cmd;
  dp_stat_t          stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q <= '0;
    end else if (psel && penable && pwrite && pready && reg_idx == REG_POOL_BASE) begin
      pool_base_q <= pwdata[ADDR_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_POOL_BASE: prdata = APB_DATA_W'(pool_base_q);
      default:       prdata = '0;
    endcase
  end

  bpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bpa_dp #(
    .POOL_PAGES (POOL_PAGES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .req_cmd_i    (s_axis_tuser),
    .req_addr_i   (s_axis_tdata),
    .base_i       (pool_base_q),
    .res_ready_i  (m_axis_tready),
    .res_valid_o  (m_axis_tvalid),
    .res_addr_o   (m_axis_tdata),
    .res_status_o (m_axis_tuser)
  );

`ifndef SYNTHESIS
  // one request at a time: after an accept the input side closes
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while another is in progress");

  // only a successful allocation carries an address
  a_addr_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata == '0)
    else $error("nonzero page address on failed request");

  // no reserved status code
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser == ST_OK || m_axis_tuser == ST_NOFREE ||
                      m_axis_tuser == ST_INVALID)
    else $error("reserved status code");
`endif

endmodule

// ===== sv/bpa_ram.sv =====
// bpa_ram: generic single-write, single-read ram with registered read data.
// no dependencies.
module bpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/bpa_ctrl.sv =====
// bpa_ctrl: request sequencer for the page allocator (accept, then execute).
// depends on bpa_pkg.
module bpa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  bpa_pkg::dp_stat_t  stat_i,
  output bpa_pkg::ctrl_cmd_t cmd_o
);
  import bpa_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;

  always_comb begin
    state_d       = state_q;
    req_ready_o   = 1'b0;
    cmd_o.load    = 1'b0;
    cmd_o.commit  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // wait while the previous result is still held
        if (!stat_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/bpa_dp.sv =====
// bpa_dp: used-bit map (ram plus per-word valid and full flags), address
// arithmetic and result register. depends on bpa_pkg and bpa_ram.
module bpa_dp #(
  parameter int POOL_PAGES = bpa_pkg::DEF_POOL_PAGES
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bpa_pkg::ctrl_cmd_t         cmd_i,
  output bpa_pkg::dp_stat_t          stat_o,
  input  logic                       req_cmd_i,
  input  logic [bpa_pkg::ADDR_W-1:0] req_addr_i,
  input  logic [bpa_pkg::ADDR_W-1:0] base_i,
  input  logic                       res_ready_i,
  output logic                       res_valid_o,
  output logic [bpa_pkg::ADDR_W-1:0] res_addr_o,
  output logic [1:0]                 res_status_o
);
  import bpa_pkg::*;

  localparam int MAP_WORDS = (POOL_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int IDX_W     = ADDR_W - PAGE_SHIFT;
  localparam int TAIL      = POOL_PAGES % WORD_BITS;
  // bits past the end of the pool in the last word always read as used
  localparam logic [WORD_BITS-1:0] LAST_PAD =
    (TAIL == 0) ? '0 : ~((64'd1 << TAIL) - 64'd1);

  logic [MAP_WORDS-1:0] vld_q;
  logic [MAP_WORDS-1:0] full_q;

  logic                 cmd_q;
  logic [WIDX_W-1:0]    word_q;
  logic [BIT_W-1:0]     bit_q;
  logic                 bad_q;

  logic                 out_valid_q;
  logic [ADDR_W-1:0]    out_addr_q;
  logic [1:0]           out_status_q;

  // accept side
  logic [ADDR_W-1:0]    base_page;
  logic [ADDR_W-1:0]    diff;
  logic [IDX_W-1:0]     free_idx;
  logic                 range_bad;
  logic [WIDX_W-1:0]    alloc_word;
  logic                 any_free;
  logic [WIDX_W-1:0]    rd_word;

  // execute side
  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] raw;
  logic [WORD_BITS-1:0] pad;
  logic [WORD_BITS-1:0] eff;
  logic [BIT_W-1:0]     alloc_bit;
  logic                 free_hit;
  logic                 fail;
  logic [WORD_BITS-1:0] wdata;
  logic                 wr_en;
  logic [ADDR_W-1:0]    alloc_addr;
  logic [1:0]           status;

  assign base_page = {base_i[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
  assign diff      = req_addr_i - base_page;
  assign free_idx  = diff[ADDR_W-1:PAGE_SHIFT];
  assign range_bad = (free_idx >= IDX_W'(POOL_PAGES));

  // lowest word that still has a free page
  always_comb begin
    alloc_word = '0;
    any_free   = 1'b0;
    for (int i = MAP_WORDS - 1; i >= 0; i--) begin
      if (!full_q[i]) begin
        alloc_word = WIDX_W'(i);
        any_free   = 1'b1;
      end
    end
  end

  assign rd_word = (req_cmd_i == CMD_FREE) ? free_idx[BIT_W +: WIDX_W] : alloc_word;

  bpa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS),
    .AW    (WIDX_W)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (word_q),
    .wdata_i (wdata),
    .re_i    (cmd_i.load),
    .raddr_i (rd_word),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q  <= req_cmd_i;
      word_q <= rd_word;
      bit_q  <= free_idx[BIT_W-1:0];
      bad_q  <= (req_cmd_i == CMD_FREE) ? range_bad : !any_free;
    end
  end

  // a word never written reads as all free
  assign raw       = vld_q[word_q] ? rdata : '0;
  assign pad       = (word_q == WIDX_W'(MAP_WORDS - 1)) ? LAST_PAD : '0;
  assign eff       = raw | pad;
  assign alloc_bit = first_zero(eff);
  assign free_hit  = eff[bit_q];
  assign alloc_addr = base_page
                    + (ADDR_W'({word_q, alloc_bit}) << PAGE_SHIFT);

  always_comb begin
    if (cmd_q == CMD_ALLOC) begin
      fail   = bad_q;
      wdata  = raw | (64'd1 << alloc_bit);
      status = bad_q ? ST_NOFREE : ST_OK;
    end else begin
      fail   = bad_q || !free_hit;
      wdata  = raw & ~(64'd1 << bit_q);
      status = fail ? ST_INVALID : ST_OK;
    end
  end

  assign wr_en = cmd_i.commit && !fail;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      full_q <= '0;
    end else if (wr_en) begin
      vld_q[word_q]  <= 1'b1;
      full_q[word_q] <= &(wdata | pad);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_addr_q   <= (cmd_q == CMD_ALLOC && !fail) ? alloc_addr : '0;
      out_status_q <= status;
    end
  end

  assign stat_o.out_busy = out_valid_q && !res_ready_i;
  assign res_valid_o     = out_valid_q;
  assign res_addr_o      = out_addr_q;
  assign res_status_o    = out_status_q;

endmodule

// ===== sim/bitmap_page_allocator_unit_test.sv =====
`timescale 1ns / 100ps
// bitmap_page_allocator_unit_test: self-checking bench for the page allocator,
// with a used-map scoreboard, stream drivers and an apb register writer.
// depends on bpa_pkg and bitmap_page_allocator_unit.
module bitmap_page_allocator_unit_test;
  import bpa_pkg::*;

  localparam int                    NUM_PAGES      = DEF_POOL_PAGES;
  localparam int                    WATCHDOG_LIMIT = 3000;
  localparam int                    HOLD_CYCLES    = 300;
  localparam int                    SETTLE_CYCLES  = 8;
  localparam int                    PHASE_ITEMS    = 340;
  localparam logic [APB_ADDR_W-1:0] POOL_BASE_ADDR = {REG_POOL_BASE, 3'b000};
  localparam logic [APB_ADDR_W-1:0] SPARE_REG_ADDR = 4'h8;

  typedef struct {
    logic [ADDR_W-1:0] page_addr;
    logic [1:0]        status;
  } page_result_t;

  // tracks the used map and pool base, predicts one result per request
  class page_map_board;
    logic [NUM_PAGES-1:0] used_pages = '0;
    logic [ADDR_W-1:0]    pool_base  = '0;
    page_result_t         expected_q[$];
    int                   mismatches = 0;
    int                   checked    = 0;
    int                   n_alloc_ok = 0;
    int                   n_no_free  = 0;
    int                   n_free_ok  = 0;
    int                   n_bad_free = 0;

    function logic [ADDR_W-1:0] base_page();
      return {pool_base[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
    endfunction

    function void write_reg(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
      // only the pool base exists, other indexes are ignored
      if (addr == POOL_BASE_ADDR) pool_base = data[ADDR_W-1:0];
    endfunction

    function void note_request(logic cmd, logic [ADDR_W-1:0] addr);
      page_result_t      r;
      logic [ADDR_W-1:0] page_off;
      logic [ADDR_W-1:0] page_idx;
      r.page_addr = '0;
      r.status    = ST_OK;
      if (cmd == CMD_ALLOC) begin
        r.status = ST_NOFREE;
        for (int i = 0; i < NUM_PAGES; i++) begin
          if (r.status == ST_NOFREE && !used_pages[i]) begin
            used_pages[i] = 1'b1;
            r.page_addr   = base_page() + (ADDR_W'(i) << PAGE_SHIFT);
            r.status      = ST_OK;
          end
        end
        if (r.status == ST_OK) n_alloc_ok++;
        else n_no_free++;
      end else begin
        // below-base addresses wrap to a huge index and fall outside
        page_off = addr - base_page();
        page_idx = page_off >> PAGE_SHIFT;
        if (page_idx >= NUM_PAGES || !used_pages[page_idx]) begin
          r.status = ST_INVALID;
          n_bad_free++;
        end else begin
          used_pages[page_idx] = 1'b0;
          n_free_ok++;
        end
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [ADDR_W-1:0] page_addr, logic [1:0] status);
      page_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected: page_addr %h status %0d",
                 $time, page_addr, status);
        mismatches++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (page_addr !== e.page_addr) begin
        $display("%0t: page_addr mismatch: expected %h actual %h",
                 $time, e.page_addr, page_addr);
        mismatches++;
      end
      if (status !== e.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d", $time, e.status, status);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [ADDR_W-1:0]     s_axis_tdata;   // [47:0] free_addr
  logic                  s_axis_tuser;   // [0] cmd
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [ADDR_W-1:0]     m_axis_tdata;   // [47:0] page_addr
  logic [1:0]            m_axis_tuser;   // [1:0] status
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  page_map_board board = new;
  bit            hold_go   = 1'b0;
  bit            hold_done = 1'b0;
  int            idle_cycles = 0;
  int            burst_left  = 0;

  bitmap_page_allocator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [ADDR_W-1:0] rand_addr();
    return ADDR_W'({$urandom(), $urandom()});
  endfunction

  // request driver: called at a falling edge, returns at a falling edge
  // with valid still high so back-to-back requests need no toggle
  task automatic send_request(logic cmd, logic [ADDR_W-1:0] addr);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = cmd;
    s_axis_tdata  = addr;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_request(cmd, addr);
    @(negedge clk_i);
  endtask

  task automatic idle_sender(int cycles);
    s_axis_tvalid = 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    board.write_reg(addr, data);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // random index of a page currently in use, -1 when the map is empty
  function automatic int pick_used_page();
    int start;
    int idx;
    start = $urandom_range(0, NUM_PAGES - 1);
    for (int k = 0; k < NUM_PAGES; k++) begin
      idx = (start + k) % NUM_PAGES;
      if (board.used_pages[idx]) return idx;
    end
    return -1;
  endfunction

  function automatic int pick_free_page();
    int start;
    int idx;
    start = $urandom_range(0, NUM_PAGES - 1);
    for (int k = 0; k < NUM_PAGES; k++) begin
      idx = (start + k) % NUM_PAGES;
      if (!board.used_pages[idx]) return idx;
    end
    return 0;
  endfunction

  function automatic logic [ADDR_W-1:0] page_to_addr(int idx);
    return board.base_page() + (ADDR_W'(idx) << PAGE_SHIFT) + ADDR_W'($urandom_range(0, 4095));
  endfunction

  task automatic sender_gap();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) idle_sender(gap);
    end
    burst_left--;
  endtask

  // mostly allocate/free of live pages, some stale and out-of-pool frees, some noise
  task automatic run_random(int count, int lead_allocs, bit mid_drain);
    int                alloc_pct;
    int                sel;
    int                idx;
    logic              cmd;
    logic [ADDR_W-1:0] addr;
    alloc_pct = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) begin
        sel = $urandom_range(0, 2);
        alloc_pct = (sel == 0) ? 15 : (sel == 1) ? 50 : 85;
      end
      if (mid_drain && i == count / 2) wait_drained();
      sender_gap();
      addr = rand_addr();
      cmd  = CMD_FREE;
      if (i < lead_allocs || $urandom_range(0, 99) < alloc_pct) begin
        cmd = CMD_ALLOC;
      end else begin
        sel = $urandom_range(0, 9);
        if (sel <= 6) begin
          idx = pick_used_page();
          addr = page_to_addr(idx < 0 ? pick_free_page() : idx);
        end else if (sel == 7) begin
          addr = page_to_addr(pick_free_page());
        end else if (sel == 8) begin
          // just past the pool end, or just below the base
          addr = ($urandom_range(0, 1) == 0) ?
                 page_to_addr($urandom_range(NUM_PAGES, NUM_PAGES + 16)) :
                 board.base_page() - ADDR_W'($urandom_range(1, 8192));
        end
      end
      send_request(cmd, addr);
    end
    s_axis_tvalid = 1'b0;
  endtask

  // receiver: changing ready pattern, plus one long hold-off on request
  initial begin
    int rx_mode;
    int rx_len;
    m_axis_tready = 1'b0;
    rx_mode = 0;
    rx_len  = 0;
    forever begin
      @(negedge clk_i);
      if (hold_go && !hold_done) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_done = 1'b1;
      end
      if (rx_len == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_len  = $urandom_range(5, 60);
      end
      rx_len--;
      case (rx_mode)
        0:       m_axis_tready = 1'b1;
        1:       m_axis_tready = $urandom_range(0, 1);
        2:       m_axis_tready = ($urandom_range(0, 3) == 0);
        default: m_axis_tready = (rx_len > 20);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_result(m_axis_tdata, m_axis_tuser);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("bitmap_page_allocator_unit_test: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [APB_DATA_W-1:0] phase_base [5];
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = CMD_ALLOC;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // a write to an unmapped index must leave the base at zero
    apb_write(SPARE_REG_ADDR, {APB_DATA_W{1'b1}});
    send_request(CMD_ALLOC, '0);
    send_request(CMD_ALLOC, {ADDR_W{1'b1}});
    send_request(CMD_ALLOC, '0);
    send_request(CMD_FREE, 48'h0000_0000_1FFF);   // offset bits ignored
    send_request(CMD_FREE, 48'h0000_0000_1000);   // already free
    send_request(CMD_ALLOC, '0);                  // reuses lowest hole
    send_request(CMD_FREE, 48'h0000_0004_0000);   // one past pool end
    send_request(CMD_FREE, {ADDR_W{1'b1}});
    send_request(CMD_FREE, 48'h0000_0003_F000);   // last page, never allocated
    send_request(CMD_FREE, 48'h0000_0000_0000);
    send_request(CMD_FREE, 48'h0000_0000_1000);
    send_request(CMD_FREE, 48'h0000_0000_2000);
    wait_drained();

    // base at the top of the space so allocations wrap past zero
    apb_write(POOL_BASE_ADDR, {APB_DATA_W{1'b1}});
    send_request(CMD_ALLOC, '0);
    send_request(CMD_ALLOC, '0);
    send_request(CMD_ALLOC, '0);
    send_request(CMD_FREE, 48'h0000_0000_0ABC);   // wrapped page
    send_request(CMD_FREE, 48'hFFFF_FFFF_EFFF);   // below base
    send_request(CMD_FREE, 48'hFFFF_FFFF_F123);
    send_request(CMD_FREE, 48'h0000_0000_1000);
    wait_drained();

    phase_base[0] = '0;
    phase_base[1] = {$urandom(), $urandom()};
    phase_base[2] = 64'h0000_FFFF_FFFF_F000;
    phase_base[3] = {16'h0, $urandom(), 16'h0};
    phase_base[4] = 64'h0000_7FFF_FFFF_FFFF;
    for (int p = 0; p < 5; p++) begin
      apb_write(POOL_BASE_ADDR, phase_base[p]);
      if (p == 1) hold_go = 1'b1;
      run_random(PHASE_ITEMS, (p == 0) ? NUM_PAGES + 4 : 0, p == 3);
      wait_drained();
    end

    if (board.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, board.pending());
      board.mismatches++;
    end
    $display("checked %0d results: %0d allocations, %0d with pool full, %0d frees, %0d rejected",
             board.checked, board.n_alloc_ok, board.n_no_free, board.n_free_ok,
             board.n_bad_free);
    $display("pool base moved through zero, top-of-space wrap and random bases");
    if (board.mismatches == 0) begin
      $display("bitmap_page_allocator_unit_test: done, clean");
    end else begin
      $display("bitmap_page_allocator_unit_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== bitmap_page_allocator_unit.f =====
sv/bpa_pkg.sv
sv/bpa_ram.sv
sv/bpa_ctrl.sv
sv/bpa_dp.sv
sv/bitmap_page_allocator_unit.sv
sim/bitmap_page_allocator_unit_test.sv
